// ===== hdl/csis_pkg.sv =====
// Shared types and constants for the instruction step core.
// Holds the opcode codes, the decoded operation enum and the queue entry type.
// No dependencies.
package csis_pkg;

    localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
    localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
    localparam logic [7:0] OPC_STA_ZP  = 8'h85;
    localparam logic [7:0] OPC_STA_ABS = 8'h8D;
    localparam logic [7:0] OPC_INX     = 8'hE8;
    localparam logic [7:0] OPC_DEX     = 8'hCA;
    localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
    localparam logic [7:0] OPC_BEQ     = 8'hF0;
    localparam logic [7:0] OPC_BNE     = 8'hD0;
    localparam logic [7:0] OPC_CMP_IMM = 8'hC9;

    localparam logic       CMD_RESET    = 1'b0;
    localparam logic [7:0] RESET_SP     = 8'hFD;
    localparam logic [7:0] RESET_STATUS = 8'h24;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 7;

    typedef enum logic [3:0] {
        OP_RESET,
        OP_LDA,
        OP_LDX,
        OP_STA_ZP,
        OP_STA_ABS,
        OP_INX,
        OP_DEX,
        OP_JMP,
        OP_BEQ,
        OP_BNE,
        OP_CMP,
        OP_TRAP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] opcode;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_uop;

endpackage

// ===== hdl/csis_front.sv =====
// Front end: accepts commands, decodes the opcode into an operation class
// and holds one decoded entry for the queue. Depends on csis_pkg.
module csis_front import csis_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_operand_lo,
    input  logic [7:0] i_operand_hi,
    output logic       o_uop_valid,
    input  logic       i_uop_ready,
    output t_uop       o_uop
);

    logic r_valid;
    t_uop r_uop;
    t_uop n_uop;
    t_op  w_op;

    always_comb begin
        if (i_cmd == CMD_RESET) begin
            w_op = OP_RESET;
        end else begin
            unique case (i_opcode)
                OPC_LDA_IMM: w_op = OP_LDA;
                OPC_LDX_IMM: w_op = OP_LDX;
                OPC_STA_ZP:  w_op = OP_STA_ZP;
                OPC_STA_ABS: w_op = OP_STA_ABS;
                OPC_INX:     w_op = OP_INX;
                OPC_DEX:     w_op = OP_DEX;
                OPC_JMP_ABS: w_op = OP_JMP;
                OPC_BEQ:     w_op = OP_BEQ;
                OPC_BNE:     w_op = OP_BNE;
                OPC_CMP_IMM: w_op = OP_CMP;
                default:     w_op = OP_TRAP;
            endcase
        end
        n_uop.op     = w_op;
        n_uop.opcode = i_opcode;
        n_uop.lo     = i_operand_lo;
        n_uop.hi     = i_operand_hi;
    end

    assign o_ready     = !r_valid || i_uop_ready;
    assign o_uop_valid = r_valid;
    assign o_uop       = r_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_uop <= n_uop;
        end
    end

endmodule

// ===== hdl/csis_queue.sv =====
// Short FIFO of decoded entries between the front end and the execute stage.
// Depends on csis_pkg.
module csis_queue import csis_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_uop i_push_uop,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_uop o_pop_uop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_uop          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_uop    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_uop;
        end
    end

endmodule

// ===== hdl/csis_back.sv =====
// Execute stage: holds the architectural registers, carries out one decoded
// entry per cycle while the output is not stalled and registers the result. Depends on csis_pkg.
module csis_back import csis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_uop_valid,
    output logic        o_uop_ready,
    input  t_uop        i_uop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic        o_write_valid,
    output logic [15:0] o_write_addr,
    output logic [7:0]  o_write_data,
    output logic        o_trapped,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_flags_out
);

    logic [15:0] r_pc;
    logic [7:0]  r_sp;
    logic [7:0]  r_acc;
    logic [7:0]  r_x;
    logic [7:0]  r_flags;
    logic [15:0] r_trap_addr;
    logic [7:0]  r_trap_code;

    logic [15:0] n_pc;
    logic [7:0]  n_sp;
    logic [7:0]  n_acc;
    logic [7:0]  n_x;
    logic [7:0]  n_flags;
    logic [15:0] n_trap_addr;
    logic [7:0]  n_trap_code;
    logic        n_wv;
    logic [15:0] n_waddr;
    logic [7:0]  n_wdata;
    logic        n_trap;

    logic        r_out_valid;
    logic [15:0] r_o_next_pc;
    logic        r_o_wv;
    logic [15:0] r_o_waddr;
    logic [7:0]  r_o_wdata;
    logic        r_o_trap;
    logic [7:0]  r_o_acc;
    logic [7:0]  r_o_x;
    logic [7:0]  r_o_flags;

    logic        w_fire;
    logic [15:0] w_abs16;
    logic [15:0] w_after1;
    logic [15:0] w_after2;
    logic [15:0] w_after3;
    logic [15:0] w_target;
    logic [7:0]  w_diff;
    logic [7:0]  w_inx;
    logic [7:0]  w_dex;

    assign o_uop_ready = !r_out_valid || i_ready;
    assign w_fire      = i_uop_valid && o_uop_ready;

    assign w_abs16  = {i_uop.hi, i_uop.lo};
    assign w_after1 = r_pc + 16'd1;
    assign w_after2 = r_pc + 16'd2;
    assign w_after3 = r_pc + 16'd3;
    assign w_target = w_after2 + {{8{i_uop.lo[7]}}, i_uop.lo};
    assign w_diff   = r_acc - i_uop.lo;
    assign w_inx    = r_x + 8'd1;
    assign w_dex    = r_x - 8'd1;

    always_comb begin
        n_pc        = r_pc;
        n_sp        = r_sp;
        n_acc       = r_acc;
        n_x         = r_x;
        n_flags     = r_flags;
        n_trap_addr = r_trap_addr;
        n_trap_code = r_trap_code;
        n_wv        = 1'b0;
        n_waddr     = '0;
        n_wdata     = '0;
        n_trap      = 1'b0;
        unique case (i_uop.op)
            OP_RESET: begin
                n_pc    = w_abs16;
                n_sp    = RESET_SP;
                n_flags = RESET_STATUS;
            end
            OP_LDA: begin
                n_acc           = i_uop.lo;
                n_flags[FLAG_Z] = (i_uop.lo == 8'd0);
                n_flags[FLAG_N] = i_uop.lo[7];
                n_pc            = w_after2;
            end
            OP_LDX: begin
                n_x             = i_uop.lo;
                n_flags[FLAG_Z] = (i_uop.lo == 8'd0);
                n_flags[FLAG_N] = i_uop.lo[7];
                n_pc            = w_after2;
            end
            OP_STA_ZP: begin
                n_wv    = 1'b1;
                n_waddr = {8'd0, i_uop.lo};
                n_wdata = r_acc;
                n_pc    = w_after2;
            end
            OP_STA_ABS: begin
                n_wv    = 1'b1;
                n_waddr = w_abs16;
                n_wdata = r_acc;
                n_pc    = w_after3;
            end
            OP_INX: begin
                n_x             = w_inx;
                n_flags[FLAG_Z] = (w_inx == 8'd0);
                n_flags[FLAG_N] = w_inx[7];
                n_pc            = w_after1;
            end
            OP_DEX: begin
                n_x             = w_dex;
                n_flags[FLAG_Z] = (w_dex == 8'd0);
                n_flags[FLAG_N] = w_dex[7];
                n_pc            = w_after1;
            end
            OP_JMP: begin
                n_pc = w_abs16;
            end
            OP_BEQ: begin
                n_pc = r_flags[FLAG_Z] ? w_target : w_after2;
            end
            OP_BNE: begin
                n_pc = r_flags[FLAG_Z] ? w_after2 : w_target;
            end
            OP_CMP: begin
                n_flags[FLAG_Z] = (r_acc == i_uop.lo);
                n_flags[FLAG_C] = (r_acc >= i_uop.lo);
                n_flags[FLAG_N] = w_diff[7];
                n_pc            = w_after2;
            end
            OP_TRAP: begin
                n_trap      = 1'b1;
                n_trap_addr = r_pc;
                n_trap_code = i_uop.opcode;
                n_pc        = w_after1;
            end
            default: begin
                n_trap = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_sp        <= '0;
            r_acc       <= '0;
            r_x         <= '0;
            r_flags     <= '0;
            r_trap_addr <= '0;
            r_trap_code <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_pc        <= n_pc;
                r_sp        <= n_sp;
                r_acc       <= n_acc;
                r_x         <= n_x;
                r_flags     <= n_flags;
                r_trap_addr <= n_trap_addr;
                r_trap_code <= n_trap_code;
            end
            if (o_uop_ready) begin
                r_out_valid <= i_uop_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_next_pc <= n_pc;
            r_o_wv      <= n_wv;
            r_o_waddr   <= n_waddr;
            r_o_wdata   <= n_wdata;
            r_o_trap    <= n_trap;
            r_o_acc     <= n_acc;
            r_o_x       <= n_x;
            r_o_flags   <= n_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_o_next_pc;
    assign o_write_valid = r_o_wv;
    assign o_write_addr  = r_o_waddr;
    assign o_write_data  = r_o_wdata;
    assign o_trapped     = r_o_trap;
    assign o_acc_out     = r_o_acc;
    assign o_x_out       = r_o_x;
    assign o_flags_out   = r_o_flags;

endmodule

// ===== hdl/cpu_subset_instruction_step_core.sv =====
// Top level of the instruction step core: front end, decoded-entry queue and
// execute stage. Depends on csis_pkg, csis_front, csis_queue, csis_back.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one command per transfer: a
//   reset command loads PC from the vector bytes, a step command executes
//   the opcode with its operand bytes at the current PC.
//   Output channel (o_valid/i_ready) carries exactly one result per command,
//   in order: next PC, optional store, trap flag, A, X and status.
//   A result passes through the front register, a queue slot and the
//   execute register, in that order, before it is valid.
//   Throughput: one command per cycle while i_ready stays high; the execute
//   stage updates all registers together and sets the rate.
//   When the receiver stalls, the output register holds its result, the
//   queue (QUEUE_DEPTH entries) and front register fill, and o_ready drops
//   only once all are full.
//   Reset (i_rst_n low, synchronous) clears all CPU registers to zero and
//   empties every stage; no result is pending afterwards.
module cpu_subset_instruction_step_core import csis_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_operand_lo,
    input  logic [7:0]  i_operand_hi,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic        o_write_valid,
    output logic [15:0] o_write_addr,
    output logic [7:0]  o_write_data,
    output logic        o_trapped,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_flags_out
);

    logic w_fq_valid;
    logic w_fq_ready;
    t_uop w_fq_uop;
    logic w_qb_valid;
    logic w_qb_ready;
    t_uop w_qb_uop;

    csis_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_opcode     (i_opcode),
        .i_operand_lo (i_operand_lo),
        .i_operand_hi (i_operand_hi),
        .o_uop_valid  (w_fq_valid),
        .i_uop_ready  (w_fq_ready),
        .o_uop        (w_fq_uop)
    );

    csis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_uop   (w_fq_uop),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_uop    (w_qb_uop)
    );

    csis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uop_valid   (w_qb_valid),
        .o_uop_ready   (w_qb_ready),
        .i_uop         (w_qb_uop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_next_pc     (o_next_pc),
        .o_write_valid (o_write_valid),
        .o_write_addr  (o_write_addr),
        .o_write_data  (o_write_data),
        .o_trapped     (o_trapped),
        .o_acc_out     (o_acc_out),
        .o_x_out       (o_x_out),
        .o_flags_out   (o_flags_out)
    );

endmodule

// ===== bench/cpu_subset_instruction_step_core_test.sv =====
// Self-checking bench for cpu_subset_instruction_step_core: a directed table, then random
// instruction streams; each result is checked against the row's given value, if any, or else
// against an in-bench CPU state predictor. Depends on csis_pkg and the core RTL.
module cpu_subset_instruction_step_core_test import csis_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_STEP = ~CMD_RESET;
    localparam logic [7:0] OPC_TRAP_LOW  = 8'h00;
    localparam logic [7:0] OPC_TRAP_HIGH = 8'hFF;

    localparam int RANDOM_ITEMS   = 750;
    localparam int DRAIN_AT       = 500;
    localparam int HOLD_AT        = 300;
    localparam int LONG_HOLD      = 80;
    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        wr_valid;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
        logic        trapped;
        logic [7:0]  acc;
        logic [7:0]  xr;
        logic [7:0]  flags;
    } t_result;

    typedef struct packed {
        logic       cmd;
        logic [7:0] op;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       has_want;
        t_result    want;
    } t_row;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    localparam t_result NO_WANT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_opcode = 8'h00;
    logic [7:0]  i_operand_lo = 8'h00;
    logic [7:0]  i_operand_hi = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_next_pc;
    logic        o_write_valid;
    logic [15:0] o_write_addr;
    logic [7:0]  o_write_data;
    logic        o_trapped;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_x_out;
    logic [7:0]  o_flags_out;

    logic        row_has_want = 1'b0;
    t_result     row_want = '0;

    t_result     expected_results[$];
    int          items_in = 0;
    int          results_out = 0;
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    logic [15:0] cpu_pc = '0;
    logic [7:0]  cpu_sp = '0;
    logic [7:0]  cpu_a = '0;
    logic [7:0]  cpu_x = '0;
    logic [7:0]  cpu_p = '0;
    logic [15:0] trap_pc = '0;
    logic [7:0]  trap_op = '0;

    logic [7:0] step_opcodes [10] = '{OPC_LDA_IMM, OPC_LDX_IMM, OPC_STA_ZP, OPC_STA_ABS,
                                      OPC_INX, OPC_DEX, OPC_JMP_ABS, OPC_BEQ, OPC_BNE,
                                      OPC_CMP_IMM};

    t_row directed_rows [24] = '{
        '{CMD_STEP, OPC_INX, 8'h00, 8'h00, 1'b1,
          '{16'h0001, 1'b0, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h01, 8'h00}},
        '{CMD_RESET, OPC_TRAP_HIGH, 8'hFC, 8'hFF, 1'b1,
          '{16'hFFFC, 1'b0, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h01, 8'h24}},
        '{CMD_STEP, OPC_LDA_IMM, 8'h00, 8'h00, 1'b1,
          '{16'hFFFE, 1'b0, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h01, 8'h26}},
        '{CMD_STEP, OPC_LDA_IMM, 8'h80, 8'h00, 1'b1,
          '{16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0, 8'h80, 8'h01, 8'hA4}},
        '{CMD_STEP, OPC_STA_ZP, 8'h12, 8'h34, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_STA_ABS, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_LDX_IMM, 8'hFF, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_INX, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_DEX, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_CMP_IMM, 8'h80, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_CMP_IMM, 8'h81, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_CMP_IMM, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BEQ, 8'h10, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BNE, 8'h80, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_JMP_ABS, 8'hFE, 8'hFF, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BNE, 8'h7F, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_LDA_IMM, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BEQ, 8'h80, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BEQ, 8'h7F, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_BNE, 8'h55, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_TRAP_LOW, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_TRAP_HIGH, 8'hFF, 8'hFF, 1'b0, NO_WANT},
        '{CMD_STEP, OPC_JMP_ABS, 8'h00, 8'h00, 1'b0, NO_WANT},
        '{CMD_RESET, OPC_LDA_IMM, 8'h00, 8'h00, 1'b1,
          '{16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0, 8'h00, 8'hFF, 8'h24}}
    };

    cpu_subset_instruction_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_opcode      (i_opcode),
        .i_operand_lo  (i_operand_lo),
        .i_operand_hi  (i_operand_hi),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_next_pc     (o_next_pc),
        .o_write_valid (o_write_valid),
        .o_write_addr  (o_write_addr),
        .o_write_data  (o_write_data),
        .o_trapped     (o_trapped),
        .o_acc_out     (o_acc_out),
        .o_x_out       (o_x_out),
        .o_flags_out   (o_flags_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void update_zn(logic [7:0] v);
        cpu_p[FLAG_Z] = (v == 8'h00);
        cpu_p[FLAG_N] = v[7];
    endfunction

    function automatic t_result execute_step(logic cmd, logic [7:0] op, logic [7:0] lo,
                                             logic [7:0] hi);
        t_result     r;
        logic [15:0] here;
        logic [15:0] abs16;
        logic [15:0] target;
        logic [7:0]  diff;
        r = '0;
        here = cpu_pc;
        abs16 = {hi, lo};
        target = here + 16'd2 + {{8{lo[7]}}, lo};
        if (cmd == CMD_RESET) begin
            cpu_pc = abs16;
            cpu_sp = RESET_SP;
            cpu_p = RESET_STATUS;
        end else begin
            case (op)
                OPC_LDA_IMM: begin
                    cpu_a = lo;
                    update_zn(cpu_a);
                    cpu_pc = here + 16'd2;
                end
                OPC_LDX_IMM: begin
                    cpu_x = lo;
                    update_zn(cpu_x);
                    cpu_pc = here + 16'd2;
                end
                OPC_STA_ZP: begin
                    r.wr_valid = 1'b1;
                    r.wr_addr = {8'h00, lo};
                    r.wr_data = cpu_a;
                    cpu_pc = here + 16'd2;
                end
                OPC_STA_ABS: begin
                    r.wr_valid = 1'b1;
                    r.wr_addr = abs16;
                    r.wr_data = cpu_a;
                    cpu_pc = here + 16'd3;
                end
                OPC_INX: begin
                    cpu_x = cpu_x + 8'd1;
                    update_zn(cpu_x);
                    cpu_pc = here + 16'd1;
                end
                OPC_DEX: begin
                    cpu_x = cpu_x - 8'd1;
                    update_zn(cpu_x);
                    cpu_pc = here + 16'd1;
                end
                OPC_JMP_ABS: begin
                    cpu_pc = abs16;
                end
                OPC_BEQ: begin
                    cpu_pc = cpu_p[FLAG_Z] ? target : here + 16'd2;
                end
                OPC_BNE: begin
                    cpu_pc = cpu_p[FLAG_Z] ? here + 16'd2 : target;
                end
                OPC_CMP_IMM: begin
                    diff = cpu_a - lo;
                    cpu_p[FLAG_Z] = (cpu_a == lo);
                    cpu_p[FLAG_C] = (cpu_a >= lo);
                    cpu_p[FLAG_N] = diff[7];
                    cpu_pc = here + 16'd2;
                end
                default: begin
                    r.trapped = 1'b1;
                    trap_pc = here;
                    trap_op = op;
                    cpu_pc = here + 16'd1;
                end
            endcase
        end
        r.next_pc = cpu_pc;
        r.acc = cpu_a;
        r.xr = cpu_x;
        r.flags = cpu_p;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corner [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 3) == 0) begin
            return corner[$urandom_range(0, 5)];
        end
        return 8'($urandom);
    endfunction

    task automatic report_error(string msg);
        $display("tb: %s", msg);
        n_errors++;
    endtask

    task automatic offer(t_row item);
        i_valid <= 1'b1;
        i_cmd <= item.cmd;
        i_opcode <= item.op;
        i_operand_lo <= item.lo;
        i_operand_hi <= item.hi;
        row_has_want <= item.has_want;
        row_want <= item.want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = execute_step(i_cmd, i_opcode, i_operand_lo, i_operand_hi);
                expected_results.push_back(row_has_want ? row_want : want);
                items_in <= items_in + 1;
            end
            if (o_valid && i_ready) begin
                got = '{o_next_pc, o_write_valid, o_write_addr, o_write_data, o_trapped,
                        o_acc_out, o_x_out, o_flags_out};
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing pending",
                                           results_out));
                end else begin
                    want = expected_results.pop_front();
                    if (got.next_pc !== want.next_pc)
                        report_error($sformatf("result %0d next_pc %h, expected %h",
                                               results_out, got.next_pc, want.next_pc));
                    if (got.wr_valid !== want.wr_valid)
                        report_error($sformatf("result %0d write_valid %b, expected %b",
                                               results_out, got.wr_valid, want.wr_valid));
                    if (got.wr_addr !== want.wr_addr)
                        report_error($sformatf("result %0d write_addr %h, expected %h",
                                               results_out, got.wr_addr, want.wr_addr));
                    if (got.wr_data !== want.wr_data)
                        report_error($sformatf("result %0d write_data %h, expected %h",
                                               results_out, got.wr_data, want.wr_data));
                    if (got.trapped !== want.trapped)
                        report_error($sformatf("result %0d trapped %b, expected %b",
                                               results_out, got.trapped, want.trapped));
                    if (got.acc !== want.acc)
                        report_error($sformatf("result %0d acc_out %h, expected %h",
                                               results_out, got.acc, want.acc));
                    if (got.xr !== want.xr)
                        report_error($sformatf("result %0d x_out %h, expected %h",
                                               results_out, got.xr, want.xr));
                    if (got.flags !== want.flags)
                        report_error($sformatf("result %0d flags_out %h, expected %h",
                                               results_out, got.flags, want.flags));
                end
                results_out++;
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       cyc;
        bit       held;
        mode = RX_OPEN;
        mode_left = 0;
        cyc = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!held && items_in >= HOLD_AT) begin
                // hold off long enough for the core to fill and drop o_ready
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:     i_ready <= 1'b1;
                    RX_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_ready <= (cyc % 3 != 0);
                    default:     i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_row item;
        int   sel;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 10);
        foreach (directed_rows[k]) begin
            offer(directed_rows[k]);
            pace();
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            item = '0;
            item.cmd = CMD_STEP;
            item.lo = pick_byte();
            item.hi = pick_byte();
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                item.cmd = CMD_RESET;
                item.op = 8'($urandom);
            end else if (sel < 86) begin
                item.op = step_opcodes[$urandom_range(0, 9)];
            end else begin
                item.op = 8'($urandom);
            end
            offer(item);
            if (n == DRAIN_AT) begin
                wait_for_results();
            end else begin
                pace();
            end
        end
        wait_for_results();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
